// ----- rtl/psxc_pkg.sv -----
// Package for the parity-selected XOR/add byte cipher: shared types, constants and
// register indexes. It depends on nothing and is compiled before all modules.
`timescale 1ns / 1ps
`default_nettype none

package psxc_pkg;

  // Configuration register width and key arithmetic widths.
  localparam int unsigned REG_W     = 31;
  localparam int unsigned EMB_W     = REG_W + 2;  // holds seed + q + 17 without wrap
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned KEY_BYTES = 8;
  localparam int unsigned POS_W     = $clog2(KEY_BYTES);

  localparam logic [EMB_W-1:0]       SEED_STEP_ADD = EMB_W'(17);
  localparam int unsigned            EMBRYO_SHIFT  = 3;

  localparam logic [REG_W-1:0] PRIME_P_RST = REG_W'(13);
  localparam logic [REG_W-1:0] PRIME_Q_RST = REG_W'(19);
  localparam logic [REG_W-1:0] SEED_S_RST  = REG_W'(0);

  typedef enum logic [1:0] {
    REG_PRIME_P = 2'd0,
    REG_PRIME_Q = 2'd1,
    REG_SEED_S  = 2'd2
  } reg_idx_t;

  typedef enum logic {
    KIND_ENCRYPT = 1'b0,
    KIND_DECRYPT = 1'b1
  } kind_t;

  // Per-word control that travels down the pipeline with the data byte.
  typedef struct packed {
    kind_t            kind;
    logic             seq_odd;
    logic [POS_W-1:0] key_pos;
    logic [7:0]       data;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/parity_selected_xor_add_byte_cipher_top.sv -----
// Top level of the parity-selected XOR/add byte cipher: configuration registers,
// stage handshake and assertions. Depends on psxc_pkg, psxc_embryo, psxc_keymul, psxc_mix.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                          Handshake
// input     in         in_kind, in_packet_seq, in_byte_index,          in_valid / in_stall
//                      in_data_byte
// result    out        out_result_byte                                out_valid / out_stall
// config    in         cfg_index, cfg_wdata                           cfg_we, no wait
//
// One word enters per cycle and one result word leaves per cycle when the
// result side does not stall. The pipeline has four registers, one each for
// the key embryos, the 33 x 31 bit key multiply, the key byte select and the
// result. Each stage holds its word while the next stage is full and stalled,
// so bubbles are squeezed out and a stall loses or repeats nothing.
// Reset is synchronous and active low; it empties the pipeline and loads the
// configuration reset values (p = 13, q = 19, s = 0).

module parity_selected_xor_add_byte_cipher_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_kind,
  input  wire logic [7:0]                    in_packet_seq,
  input  wire logic [3:0]                    in_byte_index,
  input  wire logic [7:0]                    in_data_byte,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_result_byte,
  // Configuration write port.
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [psxc_pkg::REG_W-1:0]    cfg_wdata
);

  // Configuration registers; the user must change them only while the pipeline
  // is empty; the block does not enforce it. Every stage reads them directly.
  logic [psxc_pkg::REG_W-1:0] prime_p_r;
  logic [psxc_pkg::REG_W-1:0] prime_q_r;
  logic [psxc_pkg::REG_W-1:0] seed_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_p_r <= psxc_pkg::PRIME_P_RST;
      prime_q_r <= psxc_pkg::PRIME_Q_RST;
      seed_s_r  <= psxc_pkg::SEED_S_RST;
    end else if (cfg_we) begin
      case (psxc_pkg::reg_idx_t'(cfg_index))
        psxc_pkg::REG_PRIME_P: prime_p_r <= cfg_wdata;
        psxc_pkg::REG_PRIME_Q: prime_q_r <= cfg_wdata;
        psxc_pkg::REG_SEED_S:  seed_s_r  <= cfg_wdata;
        default: ;  // Writes to unused indexes are dropped.
      endcase
    end
  end

  // Only the parity of the sequence number and the key byte position matter.
  psxc_pkg::item_t in_item;

  assign in_item.kind    = psxc_pkg::kind_t'(in_kind);
  assign in_item.seq_odd = in_packet_seq[0];
  assign in_item.key_pos = in_byte_index[psxc_pkg::POS_W-1:0];
  assign in_item.data    = in_data_byte;

  // Stage occupancy and per-stage advance. A stage loads when it is empty or
  // when its own word moves on in the same cycle.
  logic                         v1;
  logic                         v2;
  logic                         v3;
  logic                         en1;
  logic                         en2;
  logic                         en3;
  logic                         en4;
  psxc_pkg::item_t              item1;
  psxc_pkg::item_t              item2;
  logic [psxc_pkg::EMB_W-1:0]   e0_1;
  logic [psxc_pkg::EMB_W-1:0]   e1_1;
  logic [psxc_pkg::EMB_W-1:0]   e0_2;
  logic [psxc_pkg::EMB_W-1:0]   e1_2;
  logic [psxc_pkg::KEY_W-1:0]   prod0_2;
  logic [psxc_pkg::KEY_W-1:0]   prod1_2;

  assign en4      = !out_valid || !out_stall;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  psxc_embryo u_embryo (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en1),
    .in_valid (in_valid),
    .in_item  (in_item),
    .prime_p  (prime_p_r),
    .prime_q  (prime_q_r),
    .seed_s   (seed_s_r),
    .valid_r  (v1),
    .item_r   (item1),
    .e0_r     (e0_1),
    .e1_r     (e1_1)
  );

  psxc_keymul u_keymul (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en2),
    .in_valid (v1),
    .in_item  (item1),
    .e0       (e0_1),
    .e1       (e1_1),
    .prime_q  (prime_q_r),
    .valid_r  (v2),
    .item_r   (item2),
    .e0_r     (e0_2),
    .e1_r     (e1_2),
    .prod0_r  (prod0_2),
    .prod1_r  (prod1_2)
  );

  psxc_mix u_mix (
    .clk         (clk),
    .rst_n       (rst_n),
    .en_sel      (en3),
    .en_out      (en4),
    .in_valid    (v2),
    .in_item     (item2),
    .e0          (e0_2),
    .e1          (e1_2),
    .prod0       (prod0_2),
    .prod1       (prod1_2),
    .sel_valid_r (v3),
    .out_valid_r (out_valid),
    .result_r    (out_result_byte)
  );

`ifndef SYNTHESIS
  // The input side may only stall when every stage holds a word.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1 && v2 && v3 && out_valid))
    else $error("input stalled while the pipeline has room");

  // An accepted word always lands in the first stage.
  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted word did not reach the first stage");

  // A word in the select stage that moves on always becomes a result.
  a_result_from_select: assert property (@(posedge clk) disable iff (!rst_n)
    (en4 && v3) |=> out_valid)
    else $error("word in the select stage was lost on its way out");
`endif

endmodule

`default_nettype wire

// ----- rtl/psxc_embryo.sv -----
// Stage 1: captures an accepted word and forms both key embryos p ^ s0 and p ^ s1.
// Depends on psxc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psxc_embryo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire psxc_pkg::item_t               in_item,
  input  wire logic [psxc_pkg::REG_W-1:0]    prime_p,
  input  wire logic [psxc_pkg::REG_W-1:0]    prime_q,
  input  wire logic [psxc_pkg::REG_W-1:0]    seed_s,
  output logic                               valid_r,
  output psxc_pkg::item_t                    item_r,
  output logic [psxc_pkg::EMB_W-1:0]         e0_r,
  output logic [psxc_pkg::EMB_W-1:0]         e1_r
);

  logic [psxc_pkg::EMB_W-1:0] seed_w;
  logic [psxc_pkg::EMB_W-1:0] s1_w;
  logic [psxc_pkg::EMB_W-1:0] p_w;
  logic [psxc_pkg::EMB_W-1:0] e0_nxt;
  logic [psxc_pkg::EMB_W-1:0] e1_nxt;

  assign seed_w = psxc_pkg::EMB_W'(seed_s);
  assign p_w    = psxc_pkg::EMB_W'(prime_p);
  assign s1_w   = seed_w + psxc_pkg::EMB_W'(prime_q) + psxc_pkg::SEED_STEP_ADD;
  assign e0_nxt = p_w ^ seed_w;
  assign e1_nxt = p_w ^ s1_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      item_r <= in_item;
      e0_r   <= e0_nxt;
      e1_r   <= e1_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/psxc_keymul.sv -----
// Stage 2: multiplies both key embryos by prime q, keeping the low 64 bits.
// Depends on psxc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psxc_keymul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire psxc_pkg::item_t               in_item,
  input  wire logic [psxc_pkg::EMB_W-1:0]    e0,
  input  wire logic [psxc_pkg::EMB_W-1:0]    e1,
  input  wire logic [psxc_pkg::REG_W-1:0]    prime_q,
  output logic                               valid_r,
  output psxc_pkg::item_t                    item_r,
  output logic [psxc_pkg::EMB_W-1:0]         e0_r,
  output logic [psxc_pkg::EMB_W-1:0]         e1_r,
  output logic [psxc_pkg::KEY_W-1:0]         prod0_r,
  output logic [psxc_pkg::KEY_W-1:0]         prod1_r
);

  logic [psxc_pkg::KEY_W-1:0] prod0_nxt;
  logic [psxc_pkg::KEY_W-1:0] prod1_nxt;

  // 33 x 31 bit products; the result fits in 64 bits, so nothing is lost.
  assign prod0_nxt = psxc_pkg::KEY_W'(e0) * psxc_pkg::KEY_W'(prime_q);
  assign prod1_nxt = psxc_pkg::KEY_W'(e1) * psxc_pkg::KEY_W'(prime_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      item_r  <= in_item;
      e0_r    <= e0;
      e1_r    <= e1;
      prod0_r <= prod0_nxt;
      prod1_r <= prod1_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/psxc_mix.sv -----
// Stages 3 and 4: finishes both keys, picks the key bytes, then applies the
// parity-ordered XOR/add steps into the output register. Depends on psxc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psxc_mix (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en_sel,
  input  wire logic                          en_out,
  input  wire logic                          in_valid,
  input  wire psxc_pkg::item_t               in_item,
  input  wire logic [psxc_pkg::EMB_W-1:0]    e0,
  input  wire logic [psxc_pkg::EMB_W-1:0]    e1,
  input  wire logic [psxc_pkg::KEY_W-1:0]    prod0,
  input  wire logic [psxc_pkg::KEY_W-1:0]    prod1,
  output logic                               sel_valid_r,
  output logic                               out_valid_r,
  output logic [7:0]                         result_r
);

  logic [psxc_pkg::KEY_W-1:0] key0;
  logic [psxc_pkg::KEY_W-1:0] key1;
  logic [7:0]                 a_nxt;
  logic [7:0]                 b_nxt;
  logic [7:0]                 a_r;
  logic [7:0]                 b_r;
  psxc_pkg::item_t            item_r;
  logic [7:0]                 result_nxt;

  assign key0  = prod0 ^ (psxc_pkg::KEY_W'(e0) << psxc_pkg::EMBRYO_SHIFT);
  assign key1  = prod1 ^ (psxc_pkg::KEY_W'(e1) << psxc_pkg::EMBRYO_SHIFT);
  // Key bytes are taken little-endian.
  assign a_nxt = key0[{in_item.key_pos, 3'b000} +: 8];
  assign b_nxt = key1[{in_item.key_pos, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
    end else if (en_sel) begin
      sel_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_sel && in_valid) begin
      item_r <= in_item;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
    end
  end

  // Decryption undoes the encryption steps in reverse order.
  always_comb begin
    if (item_r.kind == psxc_pkg::KIND_DECRYPT) begin
      if (item_r.seq_odd) begin
        result_nxt = (item_r.data ^ b_r) - a_r;
      end else begin
        result_nxt = (item_r.data - b_r) ^ a_r;
      end
    end else begin
      if (item_r.seq_odd) begin
        result_nxt = (item_r.data + a_r) ^ b_r;
      end else begin
        result_nxt = (item_r.data ^ a_r) + b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= sel_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && sel_valid_r) begin
      result_r <= result_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/parity_selected_xor_add_byte_cipher_top_tb.sv -----
// Self-checking testbench for the parity-selected XOR/add byte cipher: random and directed
// words against an in-bench cipher predictor under several register settings.
// Depends on psxc_pkg and parity_selected_xor_add_byte_cipher_top.
`timescale 1ns / 1ps

module parity_selected_xor_add_byte_cipher_top_tb;

  // Register index that no register answers to; writes to it must be dropped.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [psxc_pkg::REG_W-1:0] REG_MAX = {psxc_pkg::REG_W{1'b1}};
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 4000;
  // Cycles to wait after the last result so that a stray extra word would show up.
  localparam int unsigned TAIL_CYCLES = 12;

  typedef struct packed {
    psxc_pkg::kind_t kind;
    logic [7:0]      seq;
    logic [3:0]      idx;
    logic [7:0]      data;
  } word_t;

  // The result side cycles through a few stall behaviors of its own.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_kind = 1'b0;
  logic [7:0]                    in_packet_seq = '0;
  logic [3:0]                    in_byte_index = '0;
  logic [7:0]                    in_data_byte = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    out_result_byte;
  logic                          cfg_we = 1'b0;
  logic [1:0]                    cfg_index = '0;
  logic [psxc_pkg::REG_W-1:0]    cfg_wdata = '0;

  // Copy of the register file as the block should hold it, kept 64 bits wide so
  // that the key arithmetic below wraps mod 2^64 exactly as the keys are defined.
  logic [63:0]          prime_p_now = 64'(psxc_pkg::PRIME_P_RST);
  logic [63:0]          prime_q_now = 64'(psxc_pkg::PRIME_Q_RST);
  logic [63:0]          seed_s_now  = 64'(psxc_pkg::SEED_S_RST);

  word_t                pending_words[$];   // words waiting to be offered
  logic [7:0]           expected_bytes[$];  // result bytes owed by the block, oldest first
  word_t                cur_word;           // word currently on the input ports
  int unsigned          words_issued = 0;
  int unsigned          words_accepted = 0;
  int unsigned          results_seen = 0;
  int unsigned          mismatches = 0;
  int unsigned          settings_run = 0;

  int unsigned          burst_left = 0;
  int unsigned          gap_left = 0;
  stall_mode_t          stall_mode = STALL_NONE;
  int unsigned          mode_left = 0;
  int unsigned          stall_tick = 0;
  int unsigned          idle_cycles = 0;

  always #5 clk = ~clk;

  parity_selected_xor_add_byte_cipher_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_packet_seq   (in_packet_seq),
    .in_byte_index   (in_byte_index),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_byte (out_result_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Key for one seed: the embryo is p XOR seed, and the key mixes the embryo
  // times q with the embryo shifted left, all modulo 2^64.
  function automatic logic [63:0] derive_key(logic [63:0] seed);
    logic [63:0] embryo;
    embryo = prime_p_now ^ seed;
    return (embryo * prime_q_now) ^ (embryo << psxc_pkg::EMBRYO_SHIFT);
  endfunction

  // Expected result byte for one word under the current register values.
  function automatic logic [7:0] cipher_byte(word_t w);
    logic [63:0] key0;
    logic [63:0] key1;
    logic [5:0]  shift;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  mid;
    key0  = derive_key(seed_s_now);
    key1  = derive_key(seed_s_now + prime_q_now + 64'(psxc_pkg::SEED_STEP_ADD));
    // Key bytes are taken little-endian, so the low three index bits pick the byte.
    shift = {w.idx[2:0], 3'b000};
    a     = 8'(key0 >> shift);
    b     = 8'(key1 >> shift);
    if (w.kind == psxc_pkg::KIND_ENCRYPT) begin
      if (!w.seq[0]) begin
        mid = w.data ^ a;
        return 8'(mid + b);
      end else begin
        mid = 8'(w.data + a);
        return mid ^ b;
      end
    end else begin
      // Decryption peels off the second encryption step first.
      if (!w.seq[0]) begin
        mid = 8'(w.data - b);
        return mid ^ a;
      end else begin
        mid = w.data ^ b;
        return 8'(mid - a);
      end
    end
  endfunction

  // Sender: works in bursts of random length separated by random gaps. A word
  // that is stalled stays on the ports unchanged until it is taken, and the
  // expectation for a word is formed at the edge where it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_bytes.push_back(cipher_byte(cur_word));
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          in_valid      <= 1'b1;
          in_kind       <= cur_word.kind;
          in_packet_seq <= cur_word.seq;
          in_byte_index <= cur_word.idx;
          in_data_byte  <= cur_word.data;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            // About a third of the bursts run straight into the next one.
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: a mode is held for a random stretch, then another is picked.
  always @(posedge clk) begin
    stall_tick++;
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(40, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_tick % 5) < 2);
    endcase
  end

  // Result checker: every word taken from the result side is matched against the
  // oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        $error("result_byte: no result expected, got %02h", out_result_byte);
        mismatches++;
      end else begin
        logic [7:0] want;
        want = expected_bytes.pop_front();
        if (out_result_byte !== want) begin
          $error("result_byte: expected %02h, got %02h", want, out_result_byte);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
      $display("parity_selected_xor_add_byte_cipher_top_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write, only issued while nothing is in flight. The copy of the
  // register file follows at the edge where the block takes the write.
  task automatic write_reg(logic [1:0] idx, logic [psxc_pkg::REG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      psxc_pkg::REG_PRIME_P: prime_p_now = 64'(value);
      psxc_pkg::REG_PRIME_Q: prime_q_now = 64'(value);
      psxc_pkg::REG_SEED_S:  seed_s_now  = 64'(value);
      default: ;
    endcase
  endtask

  task automatic write_all(logic [psxc_pkg::REG_W-1:0] p, logic [psxc_pkg::REG_W-1:0] q,
                           logic [psxc_pkg::REG_W-1:0] s);
    write_reg(psxc_pkg::REG_PRIME_P, p);
    write_reg(psxc_pkg::REG_PRIME_Q, q);
    write_reg(psxc_pkg::REG_SEED_S, s);
  endtask

  task automatic queue_word(psxc_pkg::kind_t kind, logic [7:0] seq, logic [3:0] idx,
                            logic [7:0] data);
    word_t w;
    w.kind = kind;
    w.seq  = seq;
    w.idx  = idx;
    w.data = data;
    pending_words.push_back(w);
    words_issued++;
  endtask

  // Holds the initial block until every queued word has come back as a result.
  task automatic wait_drain();
    while (results_seen < words_issued) @(posedge clk);
  endtask

  // Random words for one register setting. Most are independent words; the rest
  // are an encryption followed by the decryption of its predicted ciphertext,
  // which must give the plaintext back. Now and then the sender is held until
  // the block has emptied.
  task automatic random_words(int unsigned count);
    int unsigned n;
    int unsigned chunk;
    word_t       w;
    n = 0;
    while (n < count) begin
      chunk = $urandom_range(20, 60);
      repeat (chunk) begin
        w.kind = psxc_pkg::kind_t'($urandom_range(0, 1));
        w.seq  = 8'($urandom);
        w.idx  = 4'($urandom_range(0, 15));
        w.data = 8'($urandom);
        if ($urandom_range(0, 9) < 3) begin
          w.kind = psxc_pkg::KIND_ENCRYPT;
          queue_word(psxc_pkg::KIND_ENCRYPT, w.seq, w.idx, w.data);
          queue_word(psxc_pkg::KIND_DECRYPT, w.seq, w.idx, cipher_byte(w));
          n += 2;
        end else begin
          queue_word(w.kind, w.seq, w.idx, w.data);
          n++;
        end
      end
      if ($urandom_range(0, 3) == 0) wait_drain();
    end
    wait_drain();
    settings_run++;
  endtask

  initial begin
    logic [7:0] seq_pick[4];
    logic [7:0] data_pick[4];
    seq_pick  = '{8'h00, 8'hFF, 8'h01, 8'hFE};
    data_pick = '{8'h00, 8'hFF, 8'h80, 8'h7F};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset register values: both directions, even and
    // odd sequence numbers at their extremes, every byte index including those
    // past the eight key bytes, and extreme data bytes.
    for (int i = 0; i < 24; i++) begin
      queue_word(psxc_pkg::kind_t'(i % 2), seq_pick[(i / 2) % 4], 4'((i * 5) % 16),
                 data_pick[(i + i / 4) % 4]);
    end
    wait_drain();
    random_words(90);

    // All registers at zero.
    write_all('0, '0, '0);
    random_words(110);

    // All registers at their largest values.
    write_all(REG_MAX, REG_MAX, REG_MAX);
    random_words(110);

    // A write to the unused index must leave every register alone.
    write_reg(REG_UNUSED, psxc_pkg::REG_W'($urandom));
    write_reg(REG_UNUSED, REG_MAX);
    random_words(60);

    // Mixed extremes.
    write_all(REG_MAX, '0, psxc_pkg::REG_W'($urandom));
    random_words(100);
    write_all(psxc_pkg::REG_W'(1), psxc_pkg::REG_W'(1), REG_MAX);
    random_words(100);

    // Random settings over the full register range, one register at a time too.
    repeat (3) begin
      write_all(psxc_pkg::REG_W'($urandom), psxc_pkg::REG_W'($urandom),
                psxc_pkg::REG_W'($urandom));
      random_words(100);
    end
    write_reg(psxc_pkg::REG_SEED_S, psxc_pkg::REG_W'($urandom));
    random_words(60);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $error("result_byte: %0d expected results never arrived", expected_bytes.size());
      mismatches++;
    end

    $display("Covered %0d words over %0d register settings; %0d results checked.",
             words_accepted, settings_run, results_seen);
    $display("Both directions, both step orders and all 16 byte indexes; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("parity_selected_xor_add_byte_cipher_top_tb: clean");
    end else begin
      $display("parity_selected_xor_add_byte_cipher_top_tb: errors");
    end
    $finish;
  end

endmodule
